/* sv/pss_pkg.sv */
// ----------------------------------------------------------------------------
// pss_pkg
// shared types and constants of the position sample step sequencer
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int INTERVAL_W = 24;
  localparam int DELAY_W    = 25;
  localparam int ADJ_W      = 26;
  localparam int QUO_W      = INTERVAL_W;
  localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_SAMPLE_INTERVAL = 1'b0;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd10000;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef struct packed {
    logic capture;
    logic calc_mag;
    logic load_zero;
    logic div_start;
    logic div_step;
    logic load_run;
    logic update;
    logic write_out;
    logic out_taken;
    logic out_stop;
  } cmd_t;

  typedef struct packed {
    logic run_empty;
    logic stop;
    logic mag_zero;
    logic div_done;
  } sts_t;

endpackage

/* sv/pss_div.sv */
// ----------------------------------------------------------------------------
// pss_div
// shift-subtract divider, one quotient bit per step
// ----------------------------------------------------------------------------
module pss_div #(
  parameter int DIVISOR_W = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          step,
  input  logic [pss_pkg::QUO_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0]          divisor,
  output logic [pss_pkg::QUO_W-1:0]     quotient,
  output logic                          done
);
  import pss_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic [QUO_W-1:0]     quo_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   trial;

  assign rem_sh   = {rem_r, quo_r[QUO_W-1]};
  assign trial    = rem_sh - {1'b0, divisor};
  assign quotient = quo_r;
  assign done     = (cnt_r == DIV_CNT_W'(QUO_W));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= '0;
    end else if (step && !done) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (step && !done) begin
      if (!trial[DIVISOR_W]) begin
        rem_r <= trial[DIVISOR_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DIVISOR_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* sv/pss_dpath.sv */
// ----------------------------------------------------------------------------
// pss_dpath
// run state, sample magnitude, delay adjustment and result register
// ----------------------------------------------------------------------------
module pss_dpath #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pss_pkg::cmd_t                     cmd,
  output pss_pkg::sts_t                     sts,
  input  logic [POSITION_WIDTH-1:0]         target_position,
  input  logic                              stop_request,
  input  logic [POSITION_WIDTH-1:0]         current_position,
  input  logic                              cfg_we,
  input  logic [pss_pkg::INTERVAL_W-1:0]    cfg_interval,
  output logic [pss_pkg::INTERVAL_W-1:0]    interval,
  output logic [1:0]                        direction,
  output logic [pss_pkg::DELAY_W-1:0]       delay_us,
  output logic                              sample_taken
);
  import pss_pkg::*;

  localparam int PW = POSITION_WIDTH;

  logic [INTERVAL_W-1:0] interval_r;
  logic [PW-1:0]         diff_r;
  logic                  stop_cap_r;
  logic [PW-1:0]         mag_r;
  logic                  neg_r;
  logic [PW-1:0]         steps_r;
  logic [PW-1:0]         last_r;
  logic signed [ADJ_W-1:0] adj_r;
  dir_t                  hdir_r;
  logic [DELAY_W-1:0]    hdelay_r;
  logic [1:0]            out_dir_r;
  logic [DELAY_W-1:0]    out_delay_r;
  logic                  out_taken_r;

  logic [QUO_W-1:0]      quo;
  logic                  div_done;
  logic [ADJ_W-1:0]      q_inc;
  logic                  shrink;

  pss_div #(
    .DIVISOR_W (PW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (interval_r),
    .divisor  (mag_r),
    .quotient (quo),
    .done     (div_done)
  );

  assign q_inc  = {{(ADJ_W-QUO_W){1'b0}}, quo} + ADJ_W'(1);
  assign shrink = (last_r > mag_r);

  assign sts.run_empty = (steps_r == '0);
  assign sts.stop      = stop_cap_r;
  assign sts.mag_zero  = (mag_r == '0);
  assign sts.div_done  = div_done;

  assign interval     = interval_r;
  assign direction    = out_dir_r;
  assign delay_us     = out_delay_r;
  assign sample_taken = out_taken_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RESET;
    end else if (cfg_we) begin
      interval_r <= cfg_interval;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      diff_r     <= target_position - current_position;
      stop_cap_r <= stop_request;
    end
    if (cmd.calc_mag) begin
      neg_r <= diff_r[PW-1];
      mag_r <= diff_r[PW-1] ? (~diff_r + 1'b1) : diff_r;
    end
    if (cmd.write_out) begin
      out_taken_r <= cmd.out_taken;
      if (cmd.out_stop) begin
        out_dir_r   <= DIR_HOLD;
        out_delay_r <= '0;
      end else begin
        out_dir_r   <= hdir_r;
        out_delay_r <= hdelay_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r  <= '0;
      last_r   <= '0;
      adj_r    <= '0;
      hdir_r   <= DIR_HOLD;
      hdelay_r <= '0;
    end else if (cmd.load_zero) begin
      hdir_r   <= DIR_HOLD;
      hdelay_r <= {1'b0, interval_r};
      steps_r  <= PW'(1);
      last_r   <= '0;
    end else if (cmd.load_run) begin
      hdir_r  <= neg_r ? DIR_REV : DIR_FWD;
      steps_r <= mag_r;
      last_r  <= mag_r;
      if (shrink) begin
        hdelay_r <= {1'b0, quo};
        adj_r    <= -q_inc;
      end else begin
        hdelay_r <= q_inc[DELAY_W-1:0];
        adj_r    <= q_inc;
      end
    end else if (cmd.update) begin
      steps_r <= steps_r - 1'b1;
      if (adj_r > 0) begin
        adj_r <= adj_r - 1'b1;
        if (adj_r == ADJ_W'(1) && hdelay_r != '0) begin
          hdelay_r <= hdelay_r - 1'b1;
        end
      end else if (adj_r < 0) begin
        adj_r <= adj_r + 1'b1;
        if (adj_r == -ADJ_W'(1)) begin
          hdelay_r <= hdelay_r + 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_run |-> (div_done && mag_r != '0))
    else $error("run loaded without a finished quotient");

endmodule

/* sv/pss_ctrl.sv */
// ----------------------------------------------------------------------------
// pss_ctrl
// request sequencing: sample decision, division, update and result handoff
// ----------------------------------------------------------------------------
module pss_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pss_pkg::sts_t  sts,
  output pss_pkg::cmd_t  cmd
);
  import pss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MAG,
    S_CHECK,
    S_DIV,
    S_LOAD,
    S_UPDATE,
    S_WRITE
  } state_t;

  state_t state_r, state_nxt;
  logic   taken_r, taken_nxt;
  logic   stop_r, stop_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    taken_nxt     = taken_r;
    stop_nxt      = stop_r;
    cmd.out_taken = taken_r;
    cmd.out_stop  = stop_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        taken_nxt = sts.run_empty;
        stop_nxt  = sts.run_empty && sts.stop;
        if (!sts.run_empty) begin
          state_nxt = S_UPDATE;
        end else if (sts.stop) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cmd.calc_mag = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_CHECK: begin
        if (sts.mag_zero) begin
          cmd.load_zero = 1'b1;
          state_nxt     = S_UPDATE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_LOAD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_LOAD: begin
        cmd.load_run = 1'b1;
        state_nxt    = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          cmd.write_out = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.write_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      taken_r     <= 1'b0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      taken_r     <= taken_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while still pending");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> !sts.run_empty)
    else $error("step taken with an empty run");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write_out && cmd.out_stop) |-> (sts.run_empty && cmd.out_taken))
    else $error("stop result without a sample taken from an empty run");

endmodule

/* sv/position_sample_step_sequencer.sv */
// ----------------------------------------------------------------------------
// position_sample_step_sequencer
// turns position samples into step instructions (direction and delay)
//
//   channel   direction  signals
//   in        in         in_valid/in_ready, target_position, stop_request,
//                        current_position
//   out       out        out_valid/out_ready, direction, delay_us, sample_taken
//   cfg       in/out     apb write/read of sample_interval_us at paddr 0 to 3
//
// in a run a request passes decide, update and write, a stop decide and
// write; a zero-distance sample adds mag and check, a new run also the
// one-bit-per-cycle divider and load; one request is in flight at a time
// reset is synchronous, active low; the interval returns to 10000
// a pending result does not block the next accept, only the next handoff
// ----------------------------------------------------------------------------
module position_sample_step_sequencer #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [POSITION_WIDTH-1:0]          in_target_position,
  input  logic                               in_stop_request,
  input  logic [POSITION_WIDTH-1:0]          in_current_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_direction,
  output logic [pss_pkg::DELAY_W-1:0]        out_delay_us,
  output logic                               out_sample_taken,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pss_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [pss_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [pss_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import pss_pkg::*;

  cmd_t                  cmd;
  sts_t                  sts;
  logic                  cfg_we;
  logic                  reg_sel;
  logic [INTERVAL_W-1:0] interval;

  assign reg_sel    = (cfg_paddr[CFG_ADDR_W-1] == REG_SAMPLE_INTERVAL);
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel;
  assign cfg_prdata = reg_sel ? {{(CFG_DATA_W-INTERVAL_W){1'b0}}, interval} : '0;

  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pss_dpath #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .target_position  (in_target_position),
    .stop_request     (in_stop_request),
    .current_position (in_current_position),
    .cfg_we           (cfg_we),
    .cfg_interval     (cfg_pwdata[INTERVAL_W-1:0]),
    .interval         (interval),
    .direction        (out_direction),
    .delay_us         (out_delay_us),
    .sample_taken     (out_sample_taken)
  );

endmodule
